### sv/gwsp_pkg.sv
// ----------------------------------------------------------------------------
// gwsp_pkg
// Shared types and constants for the grid wall smoothing pass block.
// ----------------------------------------------------------------------------
package gwsp_pkg;

  localparam int GridXDef = 128;
  localparam int GridYDef = 128;

  localparam logic [2:0] TILE_WALL     = 3'd0;
  localparam logic [3:0] THRESH_RESET  = 4'd5;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PASS  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS
  } state_e;

  // one result word
  typedef struct packed {
    logic [2:0] tile;
    logic       is_read;
  } result_t;

  // smoothing engine status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } smooth_stat_t;

endpackage

### sv/gwsp_mem.sv
// ----------------------------------------------------------------------------
// gwsp_mem
// Tile store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module gwsp_mem #(
  parameter int DEPTH = gwsp_pkg::GridXDef * gwsp_pkg::GridYDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [2:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [2:0]               rdata_o
);

  logic [2:0] mem_q [DEPTH];
  logic [2:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gwsp_smooth.sv
// ----------------------------------------------------------------------------
// gwsp_smooth
// Smoothing sequencer: streams window rows out of the tile store, keeps a
// sliding window of wall flags and writes back cells that turn into walls.
// ----------------------------------------------------------------------------
module gwsp_smooth #(
  parameter int GRID_X = gwsp_pkg::GridXDef,
  parameter int GRID_Y = gwsp_pkg::GridYDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [3:0]                        thr_i,
  output logic                              re_o,
  output logic [$clog2(GRID_X*GRID_Y)-1:0]  raddr_o,
  input  logic [2:0]                        rdata_i,
  output logic                              we_o,
  output logic [$clog2(GRID_X*GRID_Y)-1:0]  waddr_o,
  output gwsp_pkg::smooth_stat_t            stat_o
);
  import gwsp_pkg::*;

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int AW = $clog2(GRID_X * GRID_Y);

  // issue side
  logic          act_q, act_d;
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [1:0]    sub_q, sub_d;
  logic [XW-1:0] src_x;
  logic          last_issue;

  // returning data tags
  logic          tag_v_q;
  logic          tag_last_q;
  logic [1:0]    tag_sub_q;
  logic [YW-1:0] tag_row_q;
  logic [XW-1:0] tag_col_q;

  // window of wall flags, rowa older than rowb
  logic [2:0] rowa_q, rowb_q, rowb_upd;
  logic       w0_q, w1_q;
  logic       wall;
  logic [2:0] new_row;
  logic [3:0] count;
  logic       turn;
  logic       full_row;

  assign last_issue = act_q && (sub_q == 2'd2) && (row_q == YW'(GRID_Y - 1))
                      && (col_q == XW'(GRID_X - 2));

  always_comb begin
    act_d = act_q;
    col_d = col_q;
    row_d = row_q;
    sub_d = sub_q;
    if (start_i) begin
      act_d = 1'b1;
      col_d = XW'(1);
      row_d = '0;
      sub_d = 2'd0;
    end else if (act_q) begin
      if (sub_q == 2'd2) begin
        sub_d = 2'd0;
        if (row_q == YW'(GRID_Y - 1)) begin
          row_d = '0;
          if (col_q == XW'(GRID_X - 2)) begin
            act_d = 1'b0;
          end else begin
            col_d = col_q + XW'(1);
          end
        end else begin
          row_d = row_q + YW'(1);
        end
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q      <= 1'b0;
      tag_v_q    <= 1'b0;
      tag_last_q <= 1'b0;
    end else begin
      act_q      <= act_d;
      tag_v_q    <= act_q;
      tag_last_q <= last_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    row_q     <= row_d;
    sub_q     <= sub_d;
    tag_sub_q <= sub_q;
    tag_row_q <= row_q;
    tag_col_q <= col_q;
  end

  // columns x-1, x, x+1 are fetched one after another for each row
  assign src_x   = XW'(int'(col_q) + int'(sub_q) - 1);
  assign re_o    = act_q;
  assign raddr_o = AW'(int'(src_x) * GRID_Y + int'(row_q));

  assign wall     = (rdata_i == TILE_WALL);
  assign new_row  = {wall, w1_q, w0_q};
  assign full_row = tag_v_q && (tag_sub_q == 2'd2);
  assign count    = 4'($countones({rowa_q, rowb_q, new_row}));
  assign turn     = full_row && (tag_row_q >= YW'(2)) && (count >= thr_i);
  assign rowb_upd = {rowb_q[2], rowb_q[1] | turn, rowb_q[0]};

  always_ff @(posedge clk_i) begin
    if (tag_v_q && (tag_sub_q == 2'd0)) begin
      w0_q <= wall;
    end
    if (tag_v_q && (tag_sub_q == 2'd1)) begin
      w1_q <= wall;
    end
    if (full_row) begin
      rowa_q <= rowb_upd;
      rowb_q <= new_row;
    end
  end

  // centre cell sits one row behind the row just completed
  assign we_o    = turn;
  assign waddr_o = AW'(int'(tag_col_q) * GRID_Y + int'(tag_row_q) - 1);

  assign stat_o.busy = act_q || tag_v_q;
  assign stat_o.done = tag_v_q && tag_last_q;

endmodule

### sv/gwsp_out_buf.sv
// ----------------------------------------------------------------------------
// gwsp_out_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module gwsp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gwsp_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gwsp_pkg::result_t out_data_o
);
  import gwsp_pkg::*;

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_v_q && !out_stall_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q || pop) begin
        out_d   = push_data_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### sv/grid_wall_smoothing_pass_top.sv
// ----------------------------------------------------------------------------
// grid_wall_smoothing_pass_top
// Tile grid with cell write/read commands and an in-place wall smoothing pass.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         in_valid_i / in_stall_o     command, x_coord, y_coord, tile_in
//  output    out        out_valid_o / out_stall_i   tile_out, is_read_result
//  config    in         cfg_we_i                    cfg_data_i (wall threshold)
//
//  write or ignored command: result word pushed on accept; read: pushed from ST_READ after the registered store read
//  pass: the single store read port fetches the three cells of each window row in turn
//  one command at a time; a new word is taken while one result waits downstream
//  reset clears control only, the tile store holds no value until written
// ----------------------------------------------------------------------------
module grid_wall_smoothing_pass_top #(
  parameter int GRID_X = gwsp_pkg::GridXDef,
  parameter int GRID_Y = gwsp_pkg::GridYDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [6:0] x_coord_i,
  input  logic [6:0] y_coord_i,
  input  logic [2:0] tile_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] tile_out_o,
  output logic       is_read_result_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i
);
  import gwsp_pkg::*;

  localparam int AW = $clog2(GRID_X * GRID_Y);

  state_e       state_q, state_d;
  logic [3:0]   thr_q;
  logic         in_grid_q, in_grid;
  logic         accept;
  logic [AW-1:0] cmd_addr;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [2:0]    mem_wdata, mem_rdata;

  logic          sm_start, sm_re, sm_we;
  logic [AW-1:0] sm_raddr, sm_waddr;
  smooth_stat_t  sm_stat;

  logic    push, buf_full;
  result_t push_data, out_data;

  assign in_grid  = (int'(x_coord_i) < GRID_X) && (int'(y_coord_i) < GRID_Y);
  assign cmd_addr = AW'(int'(x_coord_i) * GRID_Y + int'(y_coord_i));

  assign in_stall_o = (state_q != ST_IDLE) || buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    sm_start  = 1'b0;
    push      = 1'b0;
    push_data = '{tile: 3'd0, is_read: 1'b0};
    mem_we    = 1'b0;
    mem_waddr = cmd_addr;
    mem_wdata = tile_in_i;
    mem_re    = 1'b0;
    mem_raddr = cmd_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_WRITE: begin
              mem_we = in_grid;
              push   = 1'b1;
            end
            CMD_READ: begin
              mem_re  = in_grid;
              state_d = ST_READ;
            end
            CMD_PASS: begin
              sm_start = 1'b1;
              state_d  = ST_PASS;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        push      = 1'b1;
        push_data = '{tile: (in_grid_q ? mem_rdata : 3'd0), is_read: 1'b1};
        state_d   = ST_IDLE;
      end
      ST_PASS: begin
        mem_re    = sm_re;
        mem_raddr = sm_raddr;
        mem_we    = sm_we;
        mem_waddr = sm_waddr;
        mem_wdata = TILE_WALL;
        if (sm_stat.done) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= THRESH_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_grid_q <= in_grid;
    end
  end

  gwsp_mem #(
    .DEPTH (GRID_X * GRID_Y)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gwsp_smooth #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sm_start),
    .thr_i   (thr_q),
    .re_o    (sm_re),
    .raddr_o (sm_raddr),
    .rdata_i (mem_rdata),
    .we_o    (sm_we),
    .waddr_o (sm_waddr),
    .stat_o  (sm_stat)
  );

  gwsp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign tile_out_o       = out_data.tile;
  assign is_read_result_o = out_data.is_read;

`ifndef SYNTH
  // a result word must always find room in the buffer
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !buf_full)
    else $error("result pushed into full buffer");

  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_READ)) |=> (push && push_data.is_read))
    else $error("read result not produced one cycle after accept");

  // the engine runs only while the controller waits for it
  a_busy_in_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_stat.busy |-> (state_q == ST_PASS))
    else $error("smoothing engine active outside pass state");
`endif

endmodule

### verif/tb_grid_wall_smoothing_pass_top.sv
// ----------------------------------------------------------------------------
// tb_grid_wall_smoothing_pass_top
// Self-checking bench for the tile grid and its in-place wall smoothing pass.
// Fills the whole grid first, then runs a table of corner and code cases, then
// one phase per wall threshold with random writes, reads and a smoothing pass.
// Every result word is checked against a local mirror of the grid or, for typed table rows, the table.
// ----------------------------------------------------------------------------
module tb_grid_wall_smoothing_pass_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gwsp_pkg::*;

  localparam int GX = GridXDef;
  localparam int GY = GridYDef;
  localparam int HoldCycles = 60;
  localparam longint TimeoutNs = 80_000_000;

  localparam logic [1:0] CmdIgnored = 2'd3;

  localparam logic [2:0] TileBroken   = 3'd1;
  localparam logic [2:0] TileVoid     = 3'd2;
  localparam logic [2:0] TileCore     = 3'd3;
  localparam logic [2:0] TileSide     = 3'd4;
  localparam logic [2:0] TileResource = 3'd5;
  localparam logic [2:0] TileBase     = 3'd6;
  localparam logic [2:0] TileSeven    = 3'd7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] x;
    logic [6:0] y;
    logic [2:0] tile;
    logic       typed;
    logic [2:0] exp_tile;
    logic       exp_read;
  } dir_row_t;

  // corner cells, tile seven, the unused command code, then one pass and reads of the written cells
  dir_row_t dir_rows [23] = '{
    '{CMD_WRITE,  7'd0,   7'd0,   TileSeven,    1'b1, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd0,   7'd0,   TILE_WALL,    1'b1, TileSeven,    1'b1},
    '{CMD_WRITE,  7'd127, 7'd127, TileBase,     1'b1, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd127, 7'd127, TileSeven,    1'b1, TileBase,     1'b1},
    '{CMD_WRITE,  7'd127, 7'd0,   TILE_WALL,    1'b1, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd127, 7'd0,   TileSeven,    1'b1, TILE_WALL,    1'b1},
    '{CMD_WRITE,  7'd0,   7'd127, TileResource, 1'b1, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd0,   7'd127, TILE_WALL,    1'b1, TileResource, 1'b1},
    '{CmdIgnored, 7'd127, 7'd127, TileSeven,    1'b1, TILE_WALL,    1'b0},
    '{CmdIgnored, 7'd0,   7'd0,   TILE_WALL,    1'b1, TILE_WALL,    1'b0},
    '{CMD_WRITE,  7'd1,   7'd1,   TileCore,     1'b1, TILE_WALL,    1'b0},
    '{CMD_WRITE,  7'd64,  7'd64,  TileSeven,    1'b1, TILE_WALL,    1'b0},
    '{CMD_WRITE,  7'd126, 7'd126, TileSide,     1'b1, TILE_WALL,    1'b0},
    '{CMD_WRITE,  7'd1,   7'd126, TileBroken,   1'b1, TILE_WALL,    1'b0},
    '{CMD_WRITE,  7'd126, 7'd1,   TileVoid,     1'b1, TILE_WALL,    1'b0},
    '{CMD_PASS,   7'd127, 7'd127, TileSeven,    1'b1, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd0,   7'd0,   TILE_WALL,    1'b1, TileSeven,    1'b1},
    '{CMD_READ,   7'd127, 7'd127, TILE_WALL,    1'b1, TileBase,     1'b1},
    '{CMD_READ,   7'd1,   7'd1,   TILE_WALL,    1'b0, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd64,  7'd64,  TILE_WALL,    1'b0, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd126, 7'd126, TILE_WALL,    1'b0, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd1,   7'd126, TILE_WALL,    1'b0, TILE_WALL,    1'b0},
    '{CMD_READ,   7'd126, 7'd1,   TILE_WALL,    1'b0, TILE_WALL,    1'b0}
  };

  logic [3:0] phase_thresh [6] = '{4'd10, 4'd15, 4'd9, 4'd6, 4'd1, 4'd0};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [6:0] x_coord;
  logic [6:0] y_coord;
  logic [2:0] tile_in;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] tile_out;
  logic       is_read_result;
  logic       cfg_we;
  logic [3:0] cfg_data;

  // mirror of the tile store and the threshold register
  logic [2:0] grid_mirror [GX][GY];
  logic [3:0] wall_thresh_q;
  result_t    tile_results_due [$];
  result_t    due_word;
  int         mismatch_cnt;
  bit         idle_en;
  bit         hold_req;

  grid_wall_smoothing_pass_top #(
    .GRID_X(GX),
    .GRID_Y(GY)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .x_coord_i       (x_coord),
    .y_coord_i       (y_coord),
    .tile_in_i       (tile_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .tile_out_o      (tile_out),
    .is_read_result_o(is_read_result),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // in-place pass: later cells see walls already laid by earlier ones
  function automatic void smooth_grid();
    int walls;
    for (int x = 1; x < GX - 1; x++) begin
      for (int y = 1; y < GY - 1; y++) begin
        walls = 0;
        for (int i = -1; i <= 1; i++) begin
          for (int j = -1; j <= 1; j++) begin
            if (grid_mirror[x + i][y + j] == TILE_WALL) walls++;
          end
        end
        if (walls >= int'(wall_thresh_q)) grid_mirror[x][y] = TILE_WALL;
      end
    end
  endfunction

  function automatic result_t apply_grid_cmd(logic [1:0] cmd, logic [6:0] x, logic [6:0] y,
                                             logic [2:0] tile);
    result_t res;
    bit      in_grid;
    res = '0;
    in_grid = (int'(x) < GX) && (int'(y) < GY);
    case (cmd)
      CMD_WRITE: begin
        if (in_grid) grid_mirror[x][y] = tile;
      end
      CMD_READ: begin
        if (in_grid) res.tile = grid_mirror[x][y];
        res.is_read = 1'b1;
      end
      CMD_PASS: begin
        smooth_grid();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [6:0] x, input logic [6:0] y,
                           input logic [2:0] tile, input bit typed,
                           input logic [2:0] exp_tile, input logic exp_read);
    result_t res;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    x_coord  <= x;
    y_coord  <= y;
    tile_in  <= tile;
    do @(posedge clk); while (in_stall);
    res = apply_grid_cmd(cmd, x, y, tile);
    if (typed) begin
      res.tile    = exp_tile;
      res.is_read = exp_read;
    end
    tile_results_due.push_back(res);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tile_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [3:0] thr);
    wait_results_drained();
    cfg_we   <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    wall_thresh_q = thr;
  endtask

  task automatic read_block(input int x0, input int y0, input int w, input int h);
    for (int x = x0; x < x0 + w; x++) begin
      for (int y = y0; y < y0 + h; y++) begin
        send_word(CMD_READ, 7'(x), 7'(y), 3'($urandom_range(0, 7)), 1'b0, TILE_WALL, 1'b0);
      end
    end
  endtask

  initial begin
    int         sel;
    logic [1:0] r_cmd;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    command   <= CMD_WRITE;
    x_coord   <= '0;
    y_coord   <= '0;
    tile_in   <= TILE_WALL;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    wall_thresh_q = THRESH_RESET;
    mismatch_cnt  = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every cell written before any pass or read, about half of them walls
    for (int x = 0; x < GX; x++) begin
      for (int y = 0; y < GY; y++) begin
        send_word(CMD_WRITE, 7'(x), 7'(y),
                  $urandom_range(0, 1) ? TILE_WALL : 3'($urandom_range(0, 7)),
                  1'b0, TILE_WALL, 1'b0);
      end
    end

    // pass here runs at the reset threshold
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].tile,
                dir_rows[i].typed, dir_rows[i].exp_tile, dir_rows[i].exp_read);
    end
    wait_results_drained();
    read_block(0, 0, 4, 4);

    foreach (phase_thresh[p]) begin
      set_threshold(phase_thresh[p]);
      idle_en = (p % 2 == 0);
      // long downstream hold while words keep coming
      if (p == 1) hold_req = 1'b1;
      repeat (8) begin
        sel = $urandom_range(0, 19);
        r_cmd = (sel < 9) ? CMD_WRITE : (sel < 18) ? CMD_READ : CmdIgnored;
        send_word(r_cmd, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  3'($urandom_range(0, 7)), 1'b0, TILE_WALL, 1'b0);
      end
      send_word(CMD_PASS, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)), 1'b0, TILE_WALL, 1'b0);
      read_block($urandom_range(0, GX - 2), $urandom_range(0, GY - 2), 2, 2);
    end

    // closing sweep at full rate
    wait_results_drained();
    idle_en = 1'b0;
    read_block($urandom_range(0, GX - 4), $urandom_range(0, GY - 4), 4, 4);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // downstream stall: the long hold on request, short bursts otherwise while idle_en is set
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tile_results_due.size() == 0) begin
        $error("unexpected result word: tile_out %0d is_read_result %0d",
               tile_out, is_read_result);
        mismatch_cnt++;
      end else begin
        due_word = tile_results_due.pop_front();
        if (tile_out !== due_word.tile) begin
          $error("tile_out: expected %0d, got %0d", due_word.tile, tile_out);
          mismatch_cnt++;
        end
        if (is_read_result !== due_word.is_read) begin
          $error("is_read_result: expected %0d, got %0d", due_word.is_read, is_read_result);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

endmodule

### grid_wall_smoothing_pass_top.f
sv/gwsp_pkg.sv
sv/gwsp_mem.sv
sv/gwsp_smooth.sv
sv/gwsp_out_buf.sv
sv/grid_wall_smoothing_pass_top.sv
verif/tb_grid_wall_smoothing_pass_top.sv
